### rtl/assert_macros.svh
// Assertion macros shared by the palette indexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define PPI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ppi assertion failed");

// expr must never be true outside reset
`define PPI_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ppi forbidden condition");

`else

`define PPI_ASSERT(lbl, clk, rst_n, prop)
`define PPI_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

### rtl/ppi_pkg.sv
// Shared widths and controller/datapath interface types for the palette indexer.
`default_nettype none

package ppi_pkg;

    localparam int CHAN_W        = 8;
    localparam int COLOR_W       = 3 * CHAN_W;
    localparam int PIX_INDEX_W   = 4;
    localparam int ENTRY_COUNT_W = 5;

    // controller -> datapath
    typedef struct packed {
        logic load;    // take a new word, restart the scan
        logic scan;    // walk the palette one entry per cycle
        logic commit;  // append if needed and load the output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic done;      // match found or palette exhausted
        logic out_free;  // output register can take a result this cycle
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/ppi_datapath.sv
// Palette memory, sequential search, append logic and result register.
`default_nettype none

`include "assert_macros.svh"

module ppi_datapath
    import ppi_pkg::*;
#(
    parameter int PALETTE_DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_stat                      o_stat,
    input  wire logic                     i_start_image,
    input  wire logic [CHAN_W-1:0]        i_red,
    input  wire logic [CHAN_W-1:0]        i_green,
    input  wire logic [CHAN_W-1:0]        i_blue,
    input  wire logic                     i_ready,
    output logic                          o_valid,
    output logic [PIX_INDEX_W-1:0]        o_pixel_index,
    output logic                          o_new_entry,
    output logic                          o_table_full,
    output logic [ENTRY_COUNT_W-1:0]      o_entry_count
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CW = $clog2(PALETTE_DEPTH + 1);
    localparam int IW = (AW > PIX_INDEX_W) ? AW : PIX_INDEX_W;
    localparam int NW = (CW > ENTRY_COUNT_W) ? CW : ENTRY_COUNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(PALETTE_DEPTH);

    logic [COLOR_W-1:0] r_mem [PALETTE_DEPTH];

    logic [COLOR_W-1:0]       r_color;
    logic [COLOR_W-1:0]       r_rd_data;
    logic [AW-1:0]            r_rd_idx;
    logic                     r_rd_valid;
    logic [CW-1:0]            r_addr;
    logic [CW-1:0]            r_used;
    logic                     r_hit;
    logic [AW-1:0]            r_hit_idx;
    logic                     r_out_valid;
    logic [PIX_INDEX_W-1:0]   r_pixel_index;
    logic                     r_new_entry;
    logic                     r_table_full;
    logic [ENTRY_COUNT_W-1:0] r_entry_count;

    logic          rd_issue;
    logic          match;
    logic          wr_en;
    logic [AW-1:0] res_idx;
    logic [CW-1:0] n_used;
    logic [IW-1:0] idx_wide;
    logic [NW-1:0] cnt_wide;

    assign rd_issue = i_cmd.scan && !r_hit && (r_addr < r_used);
    // entries are read in order, so the first match is the lowest position
    assign match    = i_cmd.scan && r_rd_valid && !r_hit && (r_rd_data == r_color);
    assign wr_en    = i_cmd.commit && !r_hit && (r_used < DEPTH_C);

    assign n_used   = wr_en ? (r_used + CW'(1)) : r_used;
    assign res_idx  = r_hit ? r_hit_idx : (wr_en ? r_used[AW-1:0] : '0);
    assign idx_wide = IW'(res_idx);
    assign cnt_wide = NW'(n_used);

    assign o_stat.done     = r_hit || (!r_rd_valid && (r_addr >= r_used));
    assign o_stat.out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_data <= r_mem[r_addr[AW-1:0]];
        end
        if (wr_en) begin
            r_mem[r_used[AW-1:0]] <= r_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_rd_valid  <= 1'b0;
            r_hit       <= 1'b0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_addr     <= '0;
                r_rd_valid <= 1'b0;
                r_hit      <= 1'b0;
                if (i_start_image) begin
                    r_used <= '0;
                end
            end else begin
                if (rd_issue) begin
                    r_addr <= r_addr + CW'(1);
                end
                r_rd_valid <= rd_issue;
                if (match) begin
                    r_hit <= 1'b1;
                end
                r_used <= n_used;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_color <= {i_red, i_green, i_blue};
        end
        if (rd_issue) begin
            r_rd_idx <= r_addr[AW-1:0];
        end
        if (match) begin
            r_hit_idx <= r_rd_idx;
        end
        if (i_cmd.commit) begin
            r_pixel_index <= idx_wide[PIX_INDEX_W-1:0];
            r_new_entry   <= wr_en;
            r_table_full  <= !r_hit && !wr_en;
            r_entry_count <= cnt_wide[ENTRY_COUNT_W-1:0];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_index = r_pixel_index;
    assign o_new_entry   = r_new_entry;
    assign o_table_full  = r_table_full;
    assign o_entry_count = r_entry_count;

    `PPI_ASSERT_NEVER(a_used_in_range, i_clk, i_rst_n, r_used > DEPTH_C)
    `PPI_ASSERT(a_hit_below_used, i_clk, i_rst_n, r_hit |-> (CW'(r_hit_idx) < r_used))
    `PPI_ASSERT(a_append_counts, i_clk, i_rst_n, wr_en |=> (r_used == $past(r_used) + CW'(1)))

endmodule

`default_nettype wire

### rtl/ppi_ctrl.sv
// Sequencer for accept, palette scan and result commit.
`default_nettype none

`include "assert_macros.svh"

module ppi_ctrl
    import ppi_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready      = (r_state == ST_IDLE);
    assign o_cmd.load   = (r_state == ST_IDLE) && i_valid;
    assign o_cmd.scan   = (r_state == ST_SCAN);
    assign o_cmd.commit = (r_state == ST_FINISH) && i_stat.out_free;

    `PPI_ASSERT(a_cmd_onehot, i_clk, i_rst_n, $onehot0({o_cmd.load, o_cmd.scan, o_cmd.commit}))
    `PPI_ASSERT_NEVER(a_commit_needs_slot, i_clk, i_rst_n, o_cmd.commit && !i_stat.out_free)
    `PPI_ASSERT(a_commit_then_ready, i_clk, i_rst_n, o_cmd.commit |=> o_ready)

endmodule

`default_nettype wire

### rtl/pixel_palette_indexer.sv
// Pixel palette indexer: top level joining the sequencer and the datapath.
//
// Input channel: i_valid/o_ready carry one pixel word (start flag, red, green,
// blue). Output channel: o_valid/i_ready carry one result word per pixel
// (palette index, new-entry flag, table-full flag, entry count).
// Each pixel is looked up by reading the palette memory one entry per cycle
// in order of first occurrence; a color not found is appended while room
// remains, otherwise it is flagged table-full with index 0.
// The scan stops at the first match, or after all held entries on a miss;
// one pixel is in flight at a time and the next is accepted on the cycle
// after the result is loaded.
// The result sits in an output register, so a new pixel is taken while the
// previous result waits for i_ready; a stalled receiver holds the finished
// lookup until that register frees up, and stops new accepts meanwhile.
// Reset empties the palette count and drops any word in flight; the palette
// memory itself is not cleared, since only written entries are ever read.
// A start flag on a pixel empties the palette before that pixel is searched.
`default_nettype none

module pixel_palette_indexer
    import ppi_pkg::*;
#(
    parameter int PALETTE_DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic                     i_start_image,
    input  wire logic [CHAN_W-1:0]        i_red,
    input  wire logic [CHAN_W-1:0]        i_green,
    input  wire logic [CHAN_W-1:0]        i_blue,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [PIX_INDEX_W-1:0]        o_pixel_index,
    output logic                          o_new_entry,
    output logic                          o_table_full,
    output logic [ENTRY_COUNT_W-1:0]      o_entry_count
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    ppi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_cmd   (dp_cmd),
        .i_stat  (dp_stat)
    );

    ppi_datapath #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_start_image (i_start_image),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_pixel_index (o_pixel_index),
        .o_new_entry   (o_new_entry),
        .o_table_full  (o_table_full),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire

### test/pixel_palette_indexer_tb.sv
// Self-checking testbench for the pixel palette indexer: directed and random pixel streams.
`default_nettype none

module pixel_palette_indexer_tb;
    import ppi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int PIXELS_PER_PHASE = 235;

    typedef struct packed {
        logic [PIX_INDEX_W-1:0]   pixel_index;
        logic                     new_entry;
        logic                     table_full;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } t_lookup_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic                     i_start_image = 1'b0;
    logic [CHAN_W-1:0]        i_red = '0;
    logic [CHAN_W-1:0]        i_green = '0;
    logic [CHAN_W-1:0]        i_blue = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [PIX_INDEX_W-1:0]   o_pixel_index;
    logic                     o_new_entry;
    logic                     o_table_full;
    logic [ENTRY_COUNT_W-1:0] o_entry_count;

    // palette as the block should hold it
    logic [COLOR_W-1:0] palette_colors [DEPTH];
    int                 palette_used = 0;
    t_lookup_result     pending_lookups[$];
    int                 mismatch_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;

    pixel_palette_indexer #(
        .PALETTE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_start_image(i_start_image),
        .i_red(i_red),
        .i_green(i_green),
        .i_blue(i_blue),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_pixel_index(o_pixel_index),
        .o_new_entry(o_new_entry),
        .o_table_full(o_table_full),
        .o_entry_count(o_entry_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // search the palette, append on a miss, queue the expected word
    task automatic predict_lookup(input logic start, input logic [COLOR_W-1:0] color);
        t_lookup_result res;
        int             hit_at;
        int             k;
        res = '0;
        hit_at = -1;
        if (start) begin
            palette_used = 0;
        end
        for (k = 0; k < palette_used; k++) begin
            if (hit_at < 0 && palette_colors[k] == color) begin
                hit_at = k;
            end
        end
        if (hit_at >= 0) begin
            res.pixel_index = PIX_INDEX_W'(hit_at);
        end else if (palette_used < DEPTH) begin
            palette_colors[palette_used] = color;
            res.pixel_index = PIX_INDEX_W'(palette_used);
            res.new_entry = 1'b1;
            palette_used++;
        end else begin
            res.table_full = 1'b1;
        end
        res.entry_count = ENTRY_COUNT_W'(palette_used);
        pending_lookups = {pending_lookups, res};
    endtask

    // check the outgoing word first; a word accepted now cannot produce a result this edge
    always @(posedge i_clk) begin
        t_lookup_result exp_res;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_lookups.size() == 0) begin
                    $error("result word with no pixel outstanding");
                    mismatch_count++;
                end else begin
                    exp_res = pending_lookups.pop_front();
                    if (o_pixel_index !== exp_res.pixel_index) begin
                        $error("pixel_index: expected %0d, got %0d",
                               exp_res.pixel_index, o_pixel_index);
                        mismatch_count++;
                    end
                    if (o_new_entry !== exp_res.new_entry) begin
                        $error("new_entry: expected %0d, got %0d",
                               exp_res.new_entry, o_new_entry);
                        mismatch_count++;
                    end
                    if (o_table_full !== exp_res.table_full) begin
                        $error("table_full: expected %0d, got %0d",
                               exp_res.table_full, o_table_full);
                        mismatch_count++;
                    end
                    if (o_entry_count !== exp_res.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               exp_res.entry_count, o_entry_count);
                        mismatch_count++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                predict_lookup(i_start_image, {i_red, i_green, i_blue});
            end
        end
    end

    task automatic send_pixel(input logic start, input logic [COLOR_W-1:0] color);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_start_image <= start;
        i_red         <= color[23:16];
        i_green       <= color[15:8];
        i_blue        <= color[7:0];
        do @(posedge i_clk); while (!o_ready);
    endtask

    // empty palette out of reset, hits, misses, start on a pixel
    task automatic test_lookup_basics();
        send_pixel(1'b0, 24'h000000);
        send_pixel(1'b0, 24'hFFFFFF);
        send_pixel(1'b0, 24'h000000);
        send_pixel(1'b1, 24'hFFFFFF);
    endtask

    // fill all entries, overflow, hits on first and last, start while full
    task automatic test_table_full();
        int k;
        for (k = 0; k < DEPTH; k++) begin
            send_pixel(k == 0, 24'h000001 << k);
        end
        send_pixel(1'b0, 24'hFFFFFF);
        send_pixel(1'b0, 24'h000001 << (DEPTH - 1));
        send_pixel(1'b0, 24'h000001);
        send_pixel(1'b1, 24'h800000);
    endtask

    // images drawn from a small color set so hits, appends and overflow all occur
    task automatic test_random_images(input int n_pixels);
        logic [COLOR_W-1:0] color_set [24];
        logic [COLOR_W-1:0] color;
        logic               start;
        int                 n_colors;
        int                 img_len;
        int                 sent;
        int                 p;
        int                 k;
        sent = 0;
        while (sent < n_pixels) begin
            n_colors = ($urandom_range(3) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 16);
            for (k = 0; k < n_colors; k++) begin
                color_set[k] = COLOR_W'($urandom);
            end
            img_len = $urandom_range(4, 48);
            for (p = 0; p < img_len && sent < n_pixels; p++) begin
                // occasional missing start or stray start mid-image
                start = (p == 0) ? ($urandom_range(9) != 0) : ($urandom_range(63) == 0);
                case ($urandom_range(15))
                    0:       color = COLOR_W'($urandom);
                    1:       color = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
                    default: color = color_set[$urandom_range(n_colors - 1)];
                endcase
                send_pixel(start, color);
                sent++;
            end
        end
    endtask

    initial begin
        int drain_cycles;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_lookup_basics();
        test_table_full();

        send_idle_pct = 0;  recv_stall_pct = 0;
        test_random_images(PIXELS_PER_PHASE);
        send_idle_pct = 60; recv_stall_pct = 0;
        test_random_images(PIXELS_PER_PHASE);
        send_idle_pct = 0;  recv_stall_pct = 60;
        test_random_images(PIXELS_PER_PHASE);
        send_idle_pct = 23; recv_stall_pct = 23;
        test_random_images(PIXELS_PER_PHASE);

        @(negedge i_clk);
        i_valid <= 1'b0;

        drain_cycles = 0;
        while (pending_lookups.size() != 0 && drain_cycles < 20000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        if (pending_lookups.size() != 0) begin
            $error("%0d result words never arrived", pending_lookups.size());
            mismatch_count++;
        end
        repeat (DEPTH + 8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
